[rtl/bps_pkg.sv]
// Shared types, constants and sequencer encodings for the boiler plant step unit.
package bps_pkg;

    // Field and register widths.
    localparam int TEMP_W  = 20;
    localparam int PRES_W  = 21;
    localparam int LVL_W   = 15;
    localparam int FUEL_W  = 15;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Shared multiplier operand and product widths.
    localparam int OPA_W   = 24;
    localparam int OPB_W   = 20;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 58;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 34;

    typedef logic signed [OPA_W-1:0]  t_opa;
    typedef logic signed [OPB_W-1:0]  t_opb;
    typedef logic signed [PROD_W-1:0] t_prod;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_AMB = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ATM = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DT  = 2'd2;

    // Reset values.
    localparam logic [CFG_W-1:0]  AMB_RST    = 16'd6400;
    localparam logic [CFG_W-1:0]  ATM_RST    = 16'd25939;
    localparam logic [CFG_W-1:0]  DT_RST     = 16'd102;
    localparam logic [LVL_W-1:0]  LEVEL_FULL = 15'd25600;

    // Bounds.
    localparam logic [TEMP_W-1:0] T_MAX      = 20'hFFFFF;
    localparam logic [PRES_W-1:0] P_MAX      = 21'h1FFFFF;
    localparam logic [PRES_W-1:0] BOIL_POINT = 21'd25600;

    // Q.16 coefficients and Q.24 rates.
    localparam t_opb K_HEAT      = 20'sd9830;
    localparam t_opb K_LOSS      = 20'sd328;
    localparam t_opb K_VENT_COOL = 20'sd78643;
    localparam t_opb K_STEAM     = 20'sd524;
    localparam t_opb K_VENT_P    = -20'sd196608;
    localparam t_opb K_CURVE     = 20'sd88474;
    localparam t_opb K_RELAX     = 20'sd9830;

    localparam logic signed [ACC_W-1:0] MIN_VENT_COOL = 58'sd201326592;
    localparam logic signed [ACC_W-1:0] REFILL_RATE   = 58'sd6710886;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R0,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_DHI,
        ST_DLO,
        ST_DSUM,
        ST_DDIV,
        ST_APPLY,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_TEMP,
        PH_STEAM,
        PH_PUMP,
        PH_PRES
    } t_phase;

    typedef struct packed {
        logic start;
        logic reinit;
        logic valve;
        logic out_free;
    } t_seq_stat;

    typedef struct packed {
        t_state state;
        t_phase phase;
        logic   in_ready;
        logic   load_out;
    } t_seq_ctrl;

endpackage

[rtl/boiler_plant_step_unit.sv]
// Boiler plant step unit: one plant tick per input item on a shared multiplier.
// Items are taken only in the idle state, so a new item is accepted only after the last one
// has loaded its result; a reinit item goes straight from the transfer to the output state.
// The sequenced passes through the single multiplier set the pace; a waiting result does
// not block the next input, but the output state stalls until the output register is free.
// Reset restores the register reset values and the start state; no result is pending.
module boiler_plant_step_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bps_pkg::FUEL_W-1:0]    i_fuel_rate,
    input  logic                          i_valve_open,
    input  logic                          i_reinit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bps_pkg::TEMP_W-1:0]    o_temperature_now,
    output logic [bps_pkg::PRES_W-1:0]    o_pressure_now,
    output logic [bps_pkg::LVL_W-1:0]     o_level_now,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bps_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]     i_cfg_data
);
    import bps_pkg::*;

    // Configuration and plant state.
    logic [CFG_W-1:0]  r_amb, r_atm, r_dt;
    logic [TEMP_W-1:0] r_temp;
    logic [PRES_W-1:0] r_pres;
    logic [LVL_W-1:0]  r_level;

    // Item and working registers.
    logic [FUEL_W-1:0]         r_fuel;
    logic                      r_valve;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DELTA_W-1:0] r_delta;
    logic [21:0]               r_target;
    logic signed [23:0]        r_lvw;

    // Output register.
    logic              r_out_valid;
    logic [TEMP_W-1:0] r_out_temp;
    logic [PRES_W-1:0] r_out_pres;
    logic [LVL_W-1:0]  r_out_level;

    t_seq_stat w_stat;
    t_seq_ctrl w_ctrl;
    t_opa      w_opa;
    t_opb      w_opb;
    t_prod     w_prod;

    logic                    w_in_xfer;
    logic                    w_cfg_xfer;
    logic                    w_boil;
    logic [20:0]             w_d_amb;
    logic [20:0]             w_d_boil;
    logic [21:0]             w_d_atm;
    logic [22:0]             w_d_tgt;
    logic signed [ACC_W-1:0] w_prod_x;
    logic signed [ACC_W-1:0] w_cool;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [SUM_W-1:0] w_dx;
    logic signed [SUM_W-1:0] w_base;
    logic signed [SUM_W-1:0] w_sum;
    logic [TEMP_W-1:0]       w_temp_new;
    logic [PRES_W-1:0]       w_pres_new;
    logic [LVL_W-1:0]        w_level_new;

    assign w_in_xfer  = i_in_valid && w_ctrl.in_ready;
    assign w_cfg_xfer = i_cfg_valid;

    assign w_stat.start    = w_in_xfer;
    assign w_stat.reinit   = i_reinit;
    assign w_stat.valve    = r_valve;
    assign w_stat.out_free = !r_out_valid || i_out_ready;

    bps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    bps_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_opa),
        .i_b    (w_opb),
        .o_prod (w_prod)
    );

    // Differences feeding the multiplier.
    assign w_d_amb  = {1'b0, r_temp} - {5'b0, r_amb};
    assign w_d_boil = {1'b0, r_temp} - BOIL_POINT;
    assign w_d_atm  = {1'b0, r_pres} - {6'b0, r_atm};
    assign w_d_tgt  = {1'b0, r_target} - {2'b0, r_pres};
    assign w_boil   = ({1'b0, r_temp} > BOIL_POINT);

    assign w_prod_x = {{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
    assign w_cool   = (w_prod_x < MIN_VENT_COOL) ? MIN_VENT_COOL : w_prod_x;
    // Bias negative sums so that the shift truncates toward zero.
    assign w_rnd    = r_acc + (r_acc[ACC_W-1] ? {{(ACC_W-26){1'b0}}, {26{1'b1}}}
                                              : {ACC_W{1'b0}});

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (w_ctrl.state)
            ST_R0: begin
                unique case (w_ctrl.phase)
                    PH_TEMP: begin
                        w_opa = {9'b0, r_fuel};
                        w_opb = K_HEAT;
                    end
                    PH_STEAM: begin
                        w_opa = {{3{w_d_boil[20]}}, w_d_boil};
                        w_opb = K_STEAM;
                    end
                    PH_PRES: begin
                        if (r_valve) begin
                            w_opa = {{2{w_d_atm[21]}}, w_d_atm};
                            w_opb = K_VENT_P;
                        end else begin
                            w_opa = {{3{w_d_boil[20]}}, w_d_boil};
                            w_opb = K_CURVE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_R1: begin
                w_opa = {{3{w_d_amb[20]}}, w_d_amb};
                w_opb = K_LOSS;
            end
            ST_R2: begin
                if (w_ctrl.phase == PH_TEMP) begin
                    w_opa = {{3{w_d_amb[20]}}, w_d_amb};
                    w_opb = K_VENT_COOL;
                end else begin
                    w_opa = {w_d_tgt[22], w_d_tgt};
                    w_opb = K_RELAX;
                end
            end
            ST_DHI: begin
                w_opa = {{6{r_acc[40]}}, r_acc[40:23]};
                w_opb = {4'b0, r_dt};
            end
            ST_DLO: begin
                w_opa = {1'b0, r_acc[22:0]};
                w_opb = {4'b0, r_dt};
            end
            default: ;
        endcase
    end

    // Apply the per-tick change and clamp to the bounds of the current phase.
    always_comb begin
        w_dx = {{(SUM_W-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
        unique case (w_ctrl.phase)
            PH_TEMP:  w_base = $signed({14'b0, r_temp});
            PH_STEAM: w_base = $signed({19'b0, r_level});
            PH_PUMP:  w_base = {{10{r_lvw[23]}}, r_lvw};
            PH_PRES:  w_base = $signed({13'b0, r_pres});
            default:  w_base = '0;
        endcase
        w_sum = (w_ctrl.phase == PH_STEAM) ? (w_base - w_dx) : (w_base + w_dx);

        if (w_sum < $signed({18'b0, r_amb})) begin
            w_temp_new = {4'b0, r_amb};
        end else if (w_sum > $signed({14'b0, T_MAX})) begin
            w_temp_new = T_MAX;
        end else begin
            w_temp_new = w_sum[TEMP_W-1:0];
        end

        if (w_sum < $signed({18'b0, r_atm})) begin
            w_pres_new = {5'b0, r_atm};
        end else if (w_sum > $signed({13'b0, P_MAX})) begin
            w_pres_new = P_MAX;
        end else begin
            w_pres_new = w_sum[PRES_W-1:0];
        end

        if (w_sum > $signed({19'b0, LEVEL_FULL})) begin
            w_level_new = LEVEL_FULL;
        end else if (w_sum[SUM_W-1]) begin
            w_level_new = '0;
        end else begin
            w_level_new = w_sum[LVL_W-1:0];
        end
    end

    // Configuration and plant state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb   <= AMB_RST;
            r_atm   <= ATM_RST;
            r_dt    <= DT_RST;
            r_temp  <= {4'b0, AMB_RST};
            r_pres  <= {5'b0, ATM_RST};
            r_level <= LEVEL_FULL;
        end else begin
            if (w_cfg_xfer) begin
                unique case (i_cfg_index)
                    CFG_AMB: r_amb <= i_cfg_data;
                    CFG_ATM: r_atm <= i_cfg_data;
                    CFG_DT:  r_dt  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_xfer && i_reinit) begin
                r_temp  <= {4'b0, r_amb};
                r_pres  <= {5'b0, r_atm};
                r_level <= LEVEL_FULL;
            end else if (w_ctrl.state == ST_APPLY) begin
                unique case (w_ctrl.phase)
                    PH_TEMP: r_temp  <= w_temp_new;
                    PH_PUMP: r_level <= w_level_new;
                    PH_PRES: r_pres  <= w_pres_new;
                    default: ;
                endcase
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_fuel  <= i_fuel_rate;
            r_valve <= i_valve_open;
        end
        unique case (w_ctrl.state)
            ST_R1: begin
                unique case (w_ctrl.phase)
                    PH_TEMP:  r_acc <= w_prod_x;
                    PH_STEAM: r_acc <= w_boil ? w_prod_x : '0;
                    PH_PUMP:  r_acc <= (r_lvw < $signed({9'b0, LEVEL_FULL})) ? REFILL_RATE : '0;
                    PH_PRES: begin
                        if (r_valve) begin
                            r_acc <= w_prod_x;
                        end else begin
                            r_target <= {6'b0, r_atm} + (w_boil ? w_prod[37:16] : 22'd0);
                        end
                    end
                    default: ;
                endcase
            end
            ST_R2: begin
                if (w_ctrl.phase == PH_TEMP) begin
                    r_acc <= r_acc - w_prod_x;
                end
            end
            ST_R3: begin
                if (w_ctrl.phase == PH_TEMP) begin
                    if (r_valve) begin
                        r_acc <= r_acc - w_cool;
                    end
                end else begin
                    r_acc <= w_prod_x;
                end
            end
            // The high partial product lands 23 bits up; the low one is added next.
            ST_DLO:  r_acc   <= {w_prod[34:0], 23'b0};
            ST_DSUM: r_acc   <= r_acc + w_prod_x;
            ST_DDIV: r_delta <= w_rnd[ACC_W-1:26];
            ST_APPLY: begin
                if (w_ctrl.phase == PH_STEAM) begin
                    r_lvw <= w_sum[23:0];
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            r_out_temp  <= r_temp;
            r_out_pres  <= r_pres;
            r_out_level <= r_level;
        end
    end

    assign o_in_ready        = w_ctrl.in_ready;
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_temperature_now = r_out_temp;
    assign o_pressure_now    = r_out_pres;
    assign o_level_now       = r_out_level;

endmodule

[rtl/bps_mul.sv]
// Shared signed multiplier with a registered product.
module bps_mul (
    input  logic          i_clk,
    input  bps_pkg::t_opa i_a,
    input  bps_pkg::t_opb i_b,
    output bps_pkg::t_prod o_prod
);
    import bps_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[rtl/bps_ctrl.sv]
// Sequencer: runs non-reinit items through the temperature, level and pressure phases.
module bps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bps_pkg::t_seq_stat i_stat,
    output bps_pkg::t_seq_ctrl o_ctrl
);
    import bps_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_TEMP;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.start) begin
                    n_phase = PH_TEMP;
                    n_state = i_stat.reinit ? ST_OUT : ST_R0;
                end
            end
            ST_R0:    n_state = ST_R1;
            ST_R1: begin
                // Only temperature and closed-valve pressure need extra products.
                if (r_phase == PH_TEMP || (r_phase == PH_PRES && !i_stat.valve)) begin
                    n_state = ST_R2;
                end else begin
                    n_state = ST_DHI;
                end
            end
            ST_R2:    n_state = ST_R3;
            ST_R3:    n_state = ST_DHI;
            ST_DHI:   n_state = ST_DLO;
            ST_DLO:   n_state = ST_DSUM;
            ST_DSUM:  n_state = ST_DDIV;
            ST_DDIV:  n_state = ST_APPLY;
            ST_APPLY: begin
                unique case (r_phase)
                    PH_TEMP: begin
                        n_phase = PH_STEAM;
                        n_state = ST_R0;
                    end
                    PH_STEAM: begin
                        n_phase = PH_PUMP;
                        n_state = ST_R1;
                    end
                    PH_PUMP: begin
                        n_phase = PH_PRES;
                        n_state = ST_R0;
                    end
                    PH_PRES:  n_state = ST_OUT;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.state    = r_state;
        o_ctrl.phase    = r_phase;
        o_ctrl.in_ready = (r_state == ST_IDLE);
        o_ctrl.load_out = (r_state == ST_OUT) && i_stat.out_free;
    end

endmodule

[sim/boiler_plant_step_unit_tb.sv]
// Self-checking testbench for the boiler plant step unit with a built-in plant predictor.
module boiler_plant_step_unit_tb;

    import bps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_CYCLES = 40;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    // Plant coefficients: Q.16 gains, Q.24 rates, all Q.8 state.
    localparam longint HEAT_GAIN      = 64'sd9830;
    localparam longint LOSS_GAIN      = 64'sd328;
    localparam longint VENT_COOL_GAIN = 64'sd78643;
    localparam longint VENT_COOL_MIN  = 64'sd201326592;
    localparam longint STEAM_GAIN     = 64'sd524;
    localparam longint PUMP_FLOW      = 64'sd6710886;
    localparam longint VENT_P_GAIN    = 64'sd196608;
    localparam longint CURVE_GAIN     = 64'sd88474;
    localparam longint RELAX_GAIN     = 64'sd9830;
    localparam longint BOIL_Q8        = 64'sd25600;
    localparam longint FULL_Q8        = 64'sd25600;
    localparam longint TEMP_CEIL      = 64'sd1048575;
    localparam longint PRES_CEIL      = 64'sd2097151;
    localparam longint TICK_DIV       = 64'sd67108864;

    localparam int MODE_HEAT  = 0;
    localparam int MODE_VENT  = 1;
    localparam int MODE_COOL  = 2;
    localparam int MODE_NOISE = 3;

    typedef struct {
        logic [TEMP_W-1:0] temperature;
        logic [PRES_W-1:0] pressure;
        logic [LVL_W-1:0]  level;
    } t_plant_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [FUEL_W-1:0]   i_fuel_rate = '0;
    logic                i_valve_open = 1'b0;
    logic                i_reinit = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [TEMP_W-1:0]   o_temperature_now;
    logic [PRES_W-1:0]   o_pressure_now;
    logic [LVL_W-1:0]    o_level_now;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    // Predictor copy of the configuration and the plant state.
    longint amb_cfg;
    longint atm_cfg;
    longint dt_cfg;
    longint plant_temp;
    longint plant_pres;
    longint plant_level;

    t_plant_reading pending_readings[$];
    int             mismatches = 0;
    int             ticks_sent = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int unsigned    cycle_count = 0;

    boiler_plant_step_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_fuel_rate       (i_fuel_rate),
        .i_valve_open      (i_valve_open),
        .i_reinit          (i_reinit),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_temperature_now (o_temperature_now),
        .o_pressure_now    (o_pressure_now),
        .o_level_now       (o_level_now),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Change per tick: a Q.24 per second rate times dt in Q.10 seconds, truncated toward zero.
    function automatic longint per_tick(input longint rate);
        return (rate * dt_cfg) / TICK_DIV;
    endfunction

    function automatic t_plant_reading advance_plant(input logic [FUEL_W-1:0] fuel,
                                                     input logic valve, input logic reinit);
        longint t;
        longint p;
        longint lv;
        longint rate;
        longint cool;
        longint target;
        t_plant_reading r;
        if (reinit) begin
            plant_temp  = amb_cfg;
            plant_pres  = atm_cfg;
            plant_level = FULL_Q8;
        end else begin
            t = plant_temp;
            rate = longint'(fuel) * HEAT_GAIN - LOSS_GAIN * (t - amb_cfg);
            if (valve) begin
                cool = VENT_COOL_GAIN * (t - amb_cfg);
                if (cool < VENT_COOL_MIN) cool = VENT_COOL_MIN;
                rate -= cool;
            end
            t += per_tick(rate);
            if (t < amb_cfg) t = amb_cfg;
            if (t > TEMP_CEIL) t = TEMP_CEIL;
            plant_temp = t;

            lv = plant_level;
            if (t > BOIL_Q8) lv -= per_tick((t - BOIL_Q8) * STEAM_GAIN);
            if (lv < FULL_Q8) lv += per_tick(PUMP_FLOW);
            if (lv > FULL_Q8) lv = FULL_Q8;
            if (lv < 0) lv = 0;
            plant_level = lv;

            p = plant_pres;
            if (valve) begin
                p += per_tick(-VENT_P_GAIN * (p - atm_cfg));
            end else begin
                target = atm_cfg;
                if (t > BOIL_Q8) target += ((t - BOIL_Q8) * CURVE_GAIN) >>> 16;
                p += per_tick((target - p) * RELAX_GAIN);
            end
            if (p < atm_cfg) p = atm_cfg;
            if (p > PRES_CEIL) p = PRES_CEIL;
            plant_pres = p;
        end
        r.temperature = plant_temp[TEMP_W-1:0];
        r.pressure    = plant_pres[PRES_W-1:0];
        r.level       = plant_level[LVL_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_plant_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $error("result transfer with no expected reading");
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_now !== want.temperature) begin
                    $error("temperature_now: expected %0d, got %0d",
                           want.temperature, o_temperature_now);
                    mismatches++;
                end
                if (o_pressure_now !== want.pressure) begin
                    $error("pressure_now: expected %0d, got %0d", want.pressure, o_pressure_now);
                    mismatches++;
                end
                if (o_level_now !== want.level) begin
                    $error("level_now: expected %0d, got %0d", want.level, o_level_now);
                    mismatches++;
                end
            end
        end
    end

    // Valid stays high from one item to the next unless the sender decides to idle.
    task automatic send_tick(input logic [FUEL_W-1:0] fuel, input logic valve,
                             input logic reinit);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_fuel_rate  <= fuel;
        i_valve_open <= valve;
        i_reinit     <= reinit;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(advance_plant(fuel, valve, reinit));
        ticks_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_AMB: amb_cfg = longint'(data);
            CFG_ATM: atm_cfg = longint'(data);
            CFG_DT:  dt_cfg  = longint'(data);
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] amb, input logic [CFG_W-1:0] atm,
                             input logic [CFG_W-1:0] dt);
        write_reg(CFG_AMB, amb);
        write_reg(CFG_ATM, atm);
        write_reg(CFG_DT, dt);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_start_state();
        send_tick(15'd0, 1'b0, 1'b1);
        send_tick(15'd0, 1'b0, 1'b0);
        send_tick(15'd25600, 1'b1, 1'b0);
        send_tick(15'd25600, 1'b0, 1'b0);
        wait_for_results();
    endtask

    // Long ticks push the plant past boiling, drain the water and drive pressure to its ceiling.
    task automatic test_overheat();
        configure(AMB_RST, ATM_RST, 16'hFFFF);
        send_tick(15'd25600, 1'b0, 1'b1);
        repeat (4) send_tick(15'd25600, 1'b0, 1'b0);
        send_tick(15'd25600, 1'b1, 1'b0);
        send_tick(15'd1023, 1'b0, 1'b0);
        send_tick(15'd6144, 1'b1, 1'b0);
        send_tick(15'd25600, 1'b1, 1'b1);
        wait_for_results();
    endtask

    // Raising the ambient floor above the current temperature clamps the water up to the new floor.
    task automatic test_below_ambient();
        configure(AMB_RST, ATM_RST, 16'd1024);
        send_tick(15'd0, 1'b0, 1'b1);
        wait_for_results();
        configure(16'hFFFF, 16'hFFFF, 16'd1024);
        send_tick(15'd0, 1'b1, 1'b0);
        send_tick(15'd12000, 1'b0, 1'b0);
        send_tick(15'd0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_zero_step();
        write_reg(CFG_AMB, 16'd0);
        write_reg(CFG_ATM, 16'd0);
        write_reg(CFG_DT, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_tick(15'd25600, 1'b0, 1'b0);
        send_tick(15'd25600, 1'b1, 1'b0);
        send_tick(15'd0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_run(input int n_items, input int send_pct, input int recv_pct);
        int stop_at;
        int seg_left;
        int burst_left;
        int mode;
        logic [FUEL_W-1:0] fuel;
        logic valve;
        logic reinit;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = ticks_sent + n_items;
        mode = MODE_NOISE;
        while (ticks_sent < stop_at) begin
            // Each segment starts from a quiet block so the registers can change.
            wait_for_results();
            case ($urandom_range(9))
                0: configure(AMB_RST, ATM_RST, DT_RST);
                1: configure(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                             16'hFFFF);
                2: configure(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                             16'd0);
                3: configure(16'd0, 16'd0, CFG_W'($urandom_range(1, 4000)));
                4: configure(16'hFFFF, 16'hFFFF, CFG_W'($urandom_range(1, 4000)));
                default: configure(CFG_W'($urandom_range(2000, 12000)),
                                   CFG_W'($urandom_range(20000, 40000)),
                                   CFG_W'($urandom_range(50, 1500)));
            endcase
            if ($urandom_range(1) == 1) begin
                send_tick(FUEL_W'($urandom_range(25600)), 1'($urandom_range(1)), 1'b1);
            end
            seg_left = $urandom_range(40, 120);
            burst_left = 0;
            while (seg_left > 0 && ticks_sent < stop_at) begin
                if (burst_left == 0) begin
                    mode = $urandom_range(MODE_NOISE);
                    burst_left = $urandom_range(5, 40);
                end
                case (mode)
                    MODE_HEAT: begin
                        fuel  = ($urandom_range(3) == 0) ? 15'd25600
                                                         : FUEL_W'($urandom_range(18000, 25600));
                        valve = ($urandom_range(19) == 0);
                    end
                    MODE_VENT: begin
                        fuel  = FUEL_W'($urandom_range(25600));
                        valve = 1'b1;
                    end
                    MODE_COOL: begin
                        fuel  = ($urandom_range(3) == 0) ? 15'd0 : FUEL_W'($urandom_range(2000));
                        valve = 1'($urandom_range(1));
                    end
                    default: begin
                        fuel  = FUEL_W'($urandom_range(25600));
                        valve = 1'($urandom_range(1));
                    end
                endcase
                reinit = (mode == MODE_NOISE) ? ($urandom_range(9) == 0)
                                              : ($urandom_range(49) == 0);
                send_tick(fuel, valve, reinit);
                seg_left--;
                burst_left--;
            end
        end
    endtask

    initial begin
        amb_cfg     = longint'(AMB_RST);
        atm_cfg     = longint'(ATM_RST);
        dt_cfg      = longint'(DT_RST);
        plant_temp  = amb_cfg;
        plant_pres  = atm_cfg;
        plant_level = FULL_Q8;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 60;
        test_start_state();
        test_overheat();
        test_below_ambient();
        test_zero_step();

        test_random_run(630, 13, 60);
        test_random_run(630, 60, 13);
        test_random_run(630, 0, 0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
